@@ rtl/core/twtlb_pkg.sv @@
// Types and constants shared by the two-way TLB modules.
package twtlb_pkg;

  localparam int REQ_W    = 2;
  localparam int PID_W    = 5;
  localparam int PAGE_W   = 14;
  localparam int ENTRY_W  = 32;
  localparam int TAG_W    = PID_W + PAGE_W;
  localparam int STAT_W   = 2;
  localparam int FRAME_W  = 13;
  localparam int LOW_PG_W = 5;                 // page bits that enter the set hash
  localparam int HASH_W   = PID_W + LOW_PG_W;  // pid*32 + page mod 32
  localparam int PRESENT_BIT = 31;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INVAL  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD   = 2'd3;  // unused: no change, answered as a miss

  // status codes
  localparam logic [STAT_W-1:0] STAT_HIT      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_INV_DONE = 2'd3;

  typedef struct packed {
    logic               valid;
    logic               recent;
    logic [TAG_W-1:0]   tag;
    logic [ENTRY_W-1:0] entry;
  } way_t;

  typedef struct packed {
    way_t way1;
    way_t way0;
  } row_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [PID_W-1:0]   proc_id;
    logic [PAGE_W-1:0]  page_number;
    logic [ENTRY_W-1:0] page_entry;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame_number;
  } resp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

@@ rtl/core/two_way_tlb_with_lru_top.sv @@
// Top level of the two-way set-associative TLB with per-way recently-used bits.
// Each transaction on the in_ side is a lookup, insert or invalidate and gives
// exactly one transaction on the out_ side, in order. Both ways of a set live
// in one row of a synchronous set memory with a registered read; a request
// reads its row, modifies it and writes it back. After a request is accepted
// one cycle computes the set index and issues the read, the next cycle updates
// the row and loads the output register. A new request is accepted in that
// update cycle if the output is not stalled, while the last one is written back,
// but never while a row is being read. A request accepted alongside a write-back
// reads its row only after that write has landed, so no forwarding is needed.
// A stalled output holds the block in its update cycle. After reset a clearing
// pass zeroes all NUM_SETS sets of the set memory, one set per cycle; in_tready
// stays low until it ends. The set index is (proc_id*32 + page_number mod 32)
// mod NUM_SETS, computed by a reciprocal multiply and one correction step.
module two_way_tlb_with_lru_top #(
  parameter int NUM_SETS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0: proc_id[4:0], page_number[13:0], page_entry[31:0], zero pad
  input  logic [55:0] in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata, from bit 0: frame_number[12:0], zero pad
  output logic [15:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);
  import twtlb_pkg::*;

  localparam int IDX_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RECIP_SH = 20;
  localparam int RECIP    = (1 << RECIP_SH) / NUM_SETS;
  localparam int PROD_W   = HASH_W + RECIP_SH + 1;
  localparam int NQ_W     = HASH_W + 12;
  localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(NUM_SETS - 1);

  // set memory
  row_t mem_r [NUM_SETS];
  row_t rd_row_r;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  req_t             req_r;
  logic [HASH_W-1:0] quot_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r, out_valid_nxt;
  resp_t            out_r;

  // incoming fields
  req_t              in_req;
  logic [HASH_W-1:0] in_hash;
  logic [PROD_W-1:0] in_prod;
  logic              in_acc;

  // index from the registered request
  logic [HASH_W-1:0] req_hash;
  logic [NQ_W-1:0]   qn;
  logic [NQ_W-1:0]   rem;
  logic [NQ_W-1:0]   rem_fix;
  logic [IDX_W-1:0]  set_idx;

  // control
  logic             adv;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  row_t             wr_row;
  logic             out_load;
  logic             clr_inc;

  row_t  upd_row;
  resp_t upd_resp;

  assign in_req.req_type    = in_tuser;
  assign in_req.proc_id     = in_tdata[4:0];
  assign in_req.page_number = in_tdata[18:5];
  assign in_req.page_entry  = in_tdata[50:19];

  // quotient estimate, low by at most one
  assign in_hash = {in_req.proc_id, in_req.page_number[LOW_PG_W-1:0]};
  assign in_prod = PROD_W'(in_hash) * PROD_W'(RECIP);
  assign in_acc  = in_tvalid && in_tready;

  assign req_hash = {req_r.proc_id, req_r.page_number[LOW_PG_W-1:0]};
  assign qn       = NQ_W'(quot_r) * NQ_W'(NUM_SETS);
  assign rem      = NQ_W'(req_hash) - qn;
  assign rem_fix  = (rem >= NQ_W'(NUM_SETS)) ? (rem - NQ_W'(NUM_SETS)) : rem;
  assign set_idx  = rem_fix[IDX_W-1:0];

  twtlb_update u_update (
    .req     (req_r),
    .row     (rd_row_r),
    .row_nxt (upd_row),
    .resp    (upd_resp)
  );

  assign adv = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_cnt_r == LAST_SET) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (adv) state_nxt = in_tvalid ? ST_READ : ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = idx_r;
    wr_row    = upd_row;
    out_load  = 1'b0;
    clr_inc   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_idx  = clr_cnt_r;
        wr_row  = '0;
        clr_inc = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_UPDATE: begin
        wr_en     = adv;
        out_load  = adv;
        in_tready = adv;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_inc) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // request and index registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_req;
      quot_r <= in_prod[RECIP_SH +: HASH_W];
    end
    if (rd_en) idx_r <= set_idx;
    if (out_load) out_r <= upd_resp;
  end

  // set memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_idx] <= wr_row;
    if (rd_en) rd_row_r <= mem_r[set_idx];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {3'b000, out_r.frame_number};

endmodule

@@ rtl/core/twtlb_update.sv @@
// Set update: hit check, victim choice and new row for one request.
module twtlb_update (
  input  twtlb_pkg::req_t  req,
  input  twtlb_pkg::row_t  row,
  output twtlb_pkg::row_t  row_nxt,
  output twtlb_pkg::resp_t resp
);
  import twtlb_pkg::*;

  logic [TAG_W-1:0] tag;
  logic match0, match1;
  logic hit0, hit1;
  logic victim;

  assign tag    = {req.proc_id, req.page_number};
  assign match0 = row.way0.valid && (row.way0.tag == tag);
  assign match1 = row.way1.valid && (row.way1.tag == tag);
  assign hit0   = match0 && row.way0.entry[PRESENT_BIT];
  assign hit1   = match1 && row.way1.entry[PRESENT_BIT];

  // first invalid way, else the way not used last; way 0 on a tie
  always_comb begin
    if (!row.way0.valid)       victim = 1'b0;
    else if (!row.way1.valid)  victim = 1'b1;
    else if (!row.way0.recent) victim = 1'b0;
    else if (!row.way1.recent) victim = 1'b1;
    else                       victim = 1'b0;
  end

  always_comb begin
    row_nxt           = row;
    resp.status       = STAT_MISS;
    resp.frame_number = '0;
    case (req.req_type)
      REQ_LOOKUP: begin
        if (hit0) begin
          row_nxt.way0.recent = 1'b1;
          row_nxt.way1.recent = 1'b0;
          resp.status         = STAT_HIT;
          resp.frame_number   = row.way0.entry[FRAME_W-1:0];
        end else if (hit1) begin
          row_nxt.way1.recent = 1'b1;
          row_nxt.way0.recent = 1'b0;
          resp.status         = STAT_HIT;
          resp.frame_number   = row.way1.entry[FRAME_W-1:0];
        end
      end
      REQ_INSERT: begin
        if (victim) begin
          row_nxt.way1.valid  = 1'b1;
          row_nxt.way1.recent = 1'b1;
          row_nxt.way1.tag    = tag;
          row_nxt.way1.entry  = req.page_entry;
          row_nxt.way0.recent = 1'b0;
        end else begin
          row_nxt.way0.valid  = 1'b1;
          row_nxt.way0.recent = 1'b1;
          row_nxt.way0.tag    = tag;
          row_nxt.way0.entry  = req.page_entry;
          row_nxt.way1.recent = 1'b0;
        end
        resp.status       = STAT_INSERTED;
        resp.frame_number = req.page_entry[FRAME_W-1:0];
      end
      REQ_INVAL: begin
        if (match0) begin
          row_nxt.way0.valid  = 1'b0;
          row_nxt.way0.recent = 1'b0;
          row_nxt.way0.entry  = '0;
        end else if (match1) begin
          row_nxt.way1.valid  = 1'b0;
          row_nxt.way1.recent = 1'b0;
          row_nxt.way1.entry  = '0;
        end
        resp.status = STAT_INV_DONE;
      end
      default: begin
        resp.status = STAT_MISS;
      end
    endcase
  end

endmodule

@@ rtl/core/twtlb_checker.sv @@
// Port-level checks for the two-way TLB, bound to its top level.
module twtlb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tvalid,
  input logic        out_tready
);
  import twtlb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time: the read cycle never accepts
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted during set read");

  // miss and invalidate carry no frame
  a_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_MISS || out_tuser == STAT_INV_DONE) |->
      out_tdata == 16'd0)
    else $error("frame on miss or invalidate");

  // a fresh result follows an accepted request that has passed the read and update states
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 3))
    else $error("result without a request");

endmodule

bind two_way_tlb_with_lru_top twtlb_checker u_twtlb_checker (.*);

@@ sim/two_way_tlb_with_lru_chk.sv @@
// Response checker for the two-way TLB: tracks the translation state and compares every response.
module two_way_tlb_with_lru_chk #(
  parameter int NUM_SETS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [55:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  output int          mismatches,
  output int          outstanding
);
  import twtlb_pkg::*;

  localparam int WAYS = 2 * NUM_SETS;

  bit                 tlb_valid  [WAYS];
  bit                 tlb_recent [WAYS];
  logic [TAG_W-1:0]   tlb_tag    [WAYS];
  logic [ENTRY_W-1:0] tlb_pte    [WAYS];

  resp_t due_resps[$];
  resp_t got_resp;
  resp_t due_resp;
  bit    bad_resp;

  // way w of set s sits at 2*s + w
  function automatic int row_base(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
    return 2 * ((int'(pid) * 32 + int'(page[LOW_PG_W-1:0])) % NUM_SETS);
  endfunction

  function automatic void mark_recent(int base, int w);
    tlb_recent[base + w]     = 1'b1;
    tlb_recent[base + 1 - w] = 1'b0;
  endfunction

  function automatic resp_t translate_req(logic [REQ_W-1:0] req, logic [PID_W-1:0] pid,
                                          logic [PAGE_W-1:0] page, logic [ENTRY_W-1:0] pte);
    int               base;
    int               victim;
    logic [TAG_W-1:0] tag;
    resp_t            r;
    base           = row_base(pid, page);
    tag            = {pid, page};
    r.status       = STAT_MISS;
    r.frame_number = '0;
    case (req)
      REQ_LOOKUP: begin
        for (int w = 0; w < 2; w++) begin
          if (tlb_valid[base + w] && tlb_tag[base + w] == tag &&
              tlb_pte[base + w][PRESENT_BIT]) begin
            mark_recent(base, w);
            r.status       = STAT_HIT;
            r.frame_number = tlb_pte[base + w][FRAME_W-1:0];
            break;
          end
        end
      end
      REQ_INSERT: begin
        if (!tlb_valid[base])           victim = 0;
        else if (!tlb_valid[base + 1])  victim = 1;
        else if (!tlb_recent[base])     victim = 0;
        else if (!tlb_recent[base + 1]) victim = 1;
        else                            victim = 0;
        tlb_valid[base + victim] = 1'b1;
        tlb_tag[base + victim]   = tag;
        tlb_pte[base + victim]   = pte;
        mark_recent(base, victim);
        r.status       = STAT_INSERTED;
        r.frame_number = pte[FRAME_W-1:0];
      end
      REQ_INVAL: begin
        for (int w = 0; w < 2; w++) begin
          if (tlb_valid[base + w] && tlb_tag[base + w] == tag) begin
            tlb_valid[base + w]  = 1'b0;
            tlb_recent[base + w] = 1'b0;
            tlb_pte[base + w]    = '0;
            break;
          end
        end
        r.status = STAT_INV_DONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAYS; i++) begin
        tlb_valid[i]  = 1'b0;
        tlb_recent[i] = 1'b0;
      end
      due_resps.delete();
      mismatches <= 0;
    end else begin
      if (in_tvalid && in_tready)
        due_resps.push_back(translate_req(in_tuser, in_tdata[4:0], in_tdata[18:5],
                                          in_tdata[50:19]));
      if (out_tvalid && out_tready) begin
        got_resp.status       = out_tuser;
        got_resp.frame_number = out_tdata[FRAME_W-1:0];
        bad_resp              = 1'b0;
        if (due_resps.size() == 0) begin
          $display("%0t: response status %0d frame 0x%0h with no transaction outstanding",
                   $time, got_resp.status, got_resp.frame_number);
          bad_resp = 1'b1;
        end else begin
          due_resp = due_resps.pop_front();
          if (got_resp.status != due_resp.status) begin
            $display("%0t: status expected %0d got %0d", $time, due_resp.status,
                     got_resp.status);
            bad_resp = 1'b1;
          end
          if (got_resp.frame_number != due_resp.frame_number) begin
            $display("%0t: frame_number expected 0x%0h got 0x%0h", $time,
                     due_resp.frame_number, got_resp.frame_number);
            bad_resp = 1'b1;
          end
        end
        if (bad_resp) mismatches <= mismatches + 1;
      end
    end
    outstanding <= due_resps.size();
  end

endmodule

@@ sim/two_way_tlb_with_lru_top_tb.sv @@
// Testbench top for the two-way TLB: drives requests, toggles backpressure, reports the verdict.
module two_way_tlb_with_lru_top_tb;
  import twtlb_pkg::*;

  localparam int NUM_SETS     = 64;
  localparam int RANDOM_ITEMS = 540;
  localparam int POOL_SIZE    = 16;
  // ~600 transactions plus the clearing pass; this is many times the slowest legal run
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [55:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        in_tvalid  = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire  [15:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tvalid;

  int mismatches;
  int outstanding;
  int cycles        = 0;
  int send_idle_pct = 32;
  int recv_idle_pct = 67;

  // Working set of tags, four per hot set, so inserts collide and evict
  // and lookups mostly land on something that was inserted.
  logic [PID_W-1:0]  hot_pid  [POOL_SIZE];
  logic [PAGE_W-1:0] hot_page [POOL_SIZE];

  always #4 clk = ~clk;

  two_way_tlb_with_lru_top #(
    .NUM_SETS(NUM_SETS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  two_way_tlb_with_lru_chk #(
    .NUM_SETS(NUM_SETS)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("two_way_tlb_with_lru_top_tb NOT OK");
      $finish;
    end
  end

  // Pick four hot sets and spread four tags over each.
  function automatic void refill_hot_tags();
    logic [5:0]  hot_set;
    logic [31:0] rnd;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 4 == 0) hot_set = 6'($urandom_range(63));
      rnd         = $urandom;
      // set index = {pid[0], page[4:0]} for 64 sets
      hot_pid[i]  = {rnd[3:0], hot_set[5]};
      hot_page[i] = {rnd[12:4], hot_set[4:0]};
    end
  endfunction

  // One request transaction. Returns at the edge that accepted it with
  // in_tvalid still high, so back-to-back requests keep valid asserted.
  task automatic send_req(logic [REQ_W-1:0] req, logic [PID_W-1:0] pid,
                          logic [PAGE_W-1:0] page, logic [ENTRY_W-1:0] pte);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'd0, pte, page, pid};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every response has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int                 k;
    int                 pick;
    logic [ENTRY_W-1:0] pte;
    logic [REQ_W-1:0]   req;

    refill_hot_tags();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    send_req(REQ_LOOKUP, 5'd0,  14'd0,     32'h0000_0000);  // empty TLB: miss
    // set 63: pid odd, page[4:0] = 31
    send_req(REQ_INSERT, 5'd31, 14'h3FFF,  32'hFFFF_FFFF);  // all-ones fields, way 0
    send_req(REQ_LOOKUP, 5'd31, 14'h3FFF,  32'h0000_0000);  // hit, frame all ones
    send_req(REQ_INSERT, 5'd0,  14'd0,     32'h0000_0000);  // absent entry, frame 0 back
    send_req(REQ_LOOKUP, 5'd0,  14'd0,     32'hFFFF_FFFF);  // tag matches, not present: miss
    send_req(REQ_INSERT, 5'd1,  14'd31,    32'h8000_0123);  // second way of set 63
    send_req(REQ_LOOKUP, 5'd31, 14'h3FFF,  32'h0000_0000);  // way 0 becomes recent
    send_req(REQ_INSERT, 5'd3,  14'd63,    32'h8000_0AAA);  // evicts way 1
    send_req(REQ_LOOKUP, 5'd1,  14'd31,    32'h0000_0000);  // evicted: miss
    send_req(REQ_INSERT, 5'd3,  14'd63,    32'h8000_0555);  // duplicate tag lands in way 0
    send_req(REQ_LOOKUP, 5'd3,  14'd63,    32'h0000_0000);  // first matching way wins
    send_req(REQ_INVAL,  5'd3,  14'd63,    32'h0000_0000);  // drops the way 0 copy
    send_req(REQ_LOOKUP, 5'd3,  14'd63,    32'h0000_0000);  // way 1 copy still hits
    send_req(REQ_INVAL,  5'd5,  14'd5,     32'h0000_0000);  // nothing matches, still done
    // absent copy in way 0, present copy in way 1: lookup skips to way 1
    send_req(REQ_INSERT, 5'd2,  14'd2,     32'h7FFF_F234);
    send_req(REQ_INSERT, 5'd2,  14'd2,     32'h8000_0777);
    send_req(REQ_LOOKUP, 5'd2,  14'd2,     32'h0000_0000);
    send_req(REQ_RSVD,   5'd2,  14'd2,     32'hFFFF_FFFF);  // unused request code
    send_req(REQ_LOOKUP, 5'd2,  14'd2,     32'h0000_0000);  // unchanged by it
    send_req(REQ_INVAL,  5'd31, 14'h3FFF,  32'hFFFF_FFFF);
    send_req(REQ_LOOKUP, 5'd31, 14'h3FFF,  32'h0000_0000);  // gone: miss
    drain();

    // ---- random part, three backpressure phases ----
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 32; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        if (n % 60 == 0) refill_hot_tags();
        k    = $urandom_range(POOL_SIZE - 1);
        pick = $urandom_range(99);
        pte  = $urandom;
        if ($urandom_range(99) < 80) pte[PRESENT_BIT] = 1'b1;
        if (pick < 38)
          send_req(REQ_LOOKUP, hot_pid[k], hot_page[k], pte);
        else if (pick < 68)
          send_req(REQ_INSERT, hot_pid[k], hot_page[k], pte);
        else if (pick < 83)
          send_req(REQ_INVAL, hot_pid[k], hot_page[k], pte);
        else begin
          // noise: a lookup, insert or invalidate on any address
          case ($urandom_range(2))
            0:       req = REQ_LOOKUP;
            1:       req = REQ_INSERT;
            default: req = REQ_INVAL;
          endcase
          send_req(req, PID_W'($urandom), PAGE_W'($urandom), $urandom);
        end
      end
      drain();
    end

    // let any stray response show up before the verdict
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("two_way_tlb_with_lru_top_tb OK");
    else
      $display("two_way_tlb_with_lru_top_tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/twtlb_pkg.sv
rtl/core/twtlb_update.sv
rtl/core/two_way_tlb_with_lru_top.sv
rtl/core/twtlb_checker.sv
sim/two_way_tlb_with_lru_chk.sv
sim/two_way_tlb_with_lru_top_tb.sv
